// ----- design/amgs_pkg.sv -----
// shared types, codes and defaults for the adjacency matrix graph store
`timescale 1ns / 1ps
`default_nettype none

package amgs_pkg;

  localparam int DefMaxVertices = 16;
  localparam int DefWeightBits  = 16;
  localparam int CountBits      = 5;
  localparam int ResetCount     = 16;

  typedef enum logic [3:0] {
    OP_ADJ   = 4'd0,
    OP_INS   = 4'd1,
    OP_DEL   = 4'd2,
    OP_ADD   = 4'd3,
    OP_REM   = 4'd4,
    OP_FIRST = 4'd5,
    OP_NEXT  = 4'd6,
    OP_GET   = 4'd7,
    OP_SET   = 4'd8
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic [3:0]         from_vertex;
    logic [3:0]         to_vertex;
    logic signed [15:0] weight;
  } req_t;

  typedef struct packed {
    logic               status;
    logic               is_adjacent;
    logic [3:0]         neighbor;
    logic signed [15:0] edge_weight;
  } rsp_t;

  typedef logic [CountBits-1:0] cfg_t;

  // row memory commands
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } mem_cmd_t;

  // side effects decided by the row evaluation
  typedef struct packed {
    logic write_row;
    logic clear_row;
    logic set_present;
    logic clear_present;
  } eval_t;

endpackage

`default_nettype wire

// ----- design/amgs_chan_if.sv -----
// valid/ready channel carrying one payload per transfer
`timescale 1ns / 1ps
`default_nettype none

interface amgs_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/amgs_row_mem.sv -----
// row-wide adjacency memory with per-row valid bits cleared at reset
`timescale 1ns / 1ps
`default_nettype none

module amgs_row_mem
  import amgs_pkg::*;
#(
  parameter int MaxVertices = DefMaxVertices,
  parameter int WeightBits  = DefWeightBits,
  localparam int AddrBits   = $clog2(MaxVertices)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mem_cmd_t                              cmd,
  input  logic [AddrBits-1:0]                   addr,
  input  logic [MaxVertices-1:0][WeightBits-1:0] wr_row,
  output logic [MaxVertices-1:0][WeightBits-1:0] rd_row
);

  logic [MaxVertices-1:0][WeightBits-1:0] mem_q [MaxVertices];
  logic [MaxVertices-1:0][WeightBits-1:0] rd_q_r;
  logic [MaxVertices-1:0]                 row_valid_r;
  logic                                   rd_hit_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_q[addr] <= wr_row;
    end
    if (cmd.rd_en) begin
      rd_q_r   <= mem_q[addr];
      rd_hit_r <= row_valid_r[addr];
    end
  end

  // a row never written since reset or delete reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (cmd.clr_en) begin
      row_valid_r[addr] <= 1'b0;
    end else if (cmd.wr_en) begin
      row_valid_r[addr] <= 1'b1;
    end
  end

  assign rd_row = rd_hit_r ? rd_q_r : '0;

endmodule

`default_nettype wire

// ----- design/amgs_row_eval.sv -----
// decodes one request against its row: result, row update and neighbour search
`timescale 1ns / 1ps
`default_nettype none

module amgs_row_eval
  import amgs_pkg::*;
#(
  parameter int MaxVertices = DefMaxVertices,
  parameter int WeightBits  = DefWeightBits
) (
  input  req_t                                  req,
  input  logic [CountBits-1:0]                  vertex_count,
  input  logic                                  present_x,
  input  logic [MaxVertices-1:0][WeightBits-1:0] row,
  output logic [MaxVertices-1:0][WeightBits-1:0] new_row,
  output rsp_t                                  rsp,
  output eval_t                                 eff
);

  logic                   x_ok;
  logic                   xy_ok;
  logic [WeightBits-1:0]  entry_y;
  logic [WeightBits-1:0]  wr_val;
  logic [CountBits-1:0]   start;
  logic [MaxVertices-1:0] cand;
  logic                   found;
  logic [3:0]             found_idx;

  assign x_ok  = {1'b0, req.from_vertex} < vertex_count;
  assign xy_ok = x_ok && ({1'b0, req.to_vertex} < vertex_count);

  // entry selection and updated row
  always_comb begin
    entry_y = '0;
    new_row = row;
    for (int j = 0; j < MaxVertices; j++) begin
      if (j == int'(req.to_vertex)) begin
        entry_y    = row[j];
        new_row[j] = wr_val;
      end
    end
  end

  always_comb begin
    case (req.mode)
      OP_ADD:  wr_val = WeightBits'(1);
      OP_SET:  wr_val = WeightBits'(req.weight);
      default: wr_val = '0;
    endcase
  end

  // lowest nonzero column at or after the start, below the vertex count
  assign start = (req.mode == OP_NEXT) ? ({1'b0, req.to_vertex} + CountBits'(1)) : '0;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int j = 0; j < MaxVertices; j++) begin
      cand[j] = (row[j] != '0) && (j >= int'(start)) && (j < int'(vertex_count));
    end
    for (int j = MaxVertices - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found     = 1'b1;
        found_idx = 4'(j);
      end
    end
  end

  always_comb begin
    rsp = '{status: 1'b1, is_adjacent: 1'b0, neighbor: '0, edge_weight: '0};
    eff = '0;
    unique case (req.mode) inside
      OP_ADJ, OP_GET: begin
        if (xy_ok) begin
          rsp.status      = 1'b0;
          rsp.is_adjacent = (entry_y != '0);
          if (req.mode == OP_GET) begin
            rsp.edge_weight = 16'($signed(entry_y));
          end
        end
      end
      OP_INS: begin
        if (x_ok) begin
          rsp.status      = 1'b0;
          eff.set_present = 1'b1;
        end
      end
      OP_DEL: begin
        if (x_ok) begin
          rsp.status        = 1'b0;
          eff.clear_present = 1'b1;
          eff.clear_row     = 1'b1;
        end
      end
      OP_ADD, OP_REM, OP_SET: begin
        if (xy_ok) begin
          rsp.status    = 1'b0;
          eff.write_row = 1'b1;
        end
      end
      OP_FIRST, OP_NEXT: begin
        if (((req.mode == OP_FIRST) ? x_ok : xy_ok) && present_x && found) begin
          rsp.status   = 1'b0;
          rsp.neighbor = found_idx;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/adjacency_matrix_graph_store.sv -----
// top level of the directed graph adjacency matrix store
// usage:
//   in_chan   requests (mode, from_vertex, to_vertex, weight), one transfer
//             per valid/ready handshake; every request gives one result
//   out_chan  results (status, is_adjacent, neighbor, edge_weight) from an
//             output register, so a stalled receiver does not block the
//             next request from being taken
//   cfg_chan  vertices_in_use, for the user to write only while the block is
//             idle (the block does not enforce this); values above MaxVertices saturate
// timing:
//   the transfer cycle reads the row of from_vertex into the row memory's
//   read register; the EXEC state then evaluates, writes back and
//   registers the result once the output register can take it; a new
//   request is taken only after that, set by the read-then-write row memory
// reset (rst_n, synchronous, active low):
//   all rows read as cleared at once through per-row valid bits and the
//   present flags clear, no clearing pass; vertices_in_use returns to 16 (capped)
// back-pressure:
//   while a result waits, a further request is read and then held until
//   the output register frees up
`timescale 1ns / 1ps
`default_nettype none

module adjacency_matrix_graph_store
  import amgs_pkg::*;
#(
  parameter int MaxVertices = DefMaxVertices,
  parameter int WeightBits  = DefWeightBits
) (
  input  logic         clk,
  input  logic         rst_n,
  amgs_chan_if.sink    in_chan,
  amgs_chan_if.source  out_chan,
  amgs_chan_if.sink    cfg_chan
);

  localparam int AddrBits = $clog2(MaxVertices);

  state_t                                 state_r, state_nxt;
  req_t                                   req_r;
  cfg_t                                   count_r;
  logic [MaxVertices-1:0]                 present_r;
  logic                                   out_valid_r, out_valid_nxt;
  rsp_t                                   out_data_r;

  logic                                   in_xfer;
  logic                                   fire;
  mem_cmd_t                               cmd;
  logic [AddrBits-1:0]                    mem_addr;
  logic [AddrBits-1:0]                    x_idx;
  logic [MaxVertices-1:0][WeightBits-1:0] rd_row;
  logic [MaxVertices-1:0][WeightBits-1:0] new_row;
  rsp_t                                   rsp;
  eval_t                                  eff;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign x_idx    = AddrBits'(req_r.from_vertex);
  // read address comes from the incoming request, write address from the held one
  assign mem_addr = (state_r == ST_IDLE) ? AddrBits'(in_chan.data.from_vertex) : x_idx;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_EXEC;
      ST_EXEC: if (fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_chan.ready = 1'b0;
    fire          = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        // always ready here, so valid alone marks the transfer
        in_chan.ready = 1'b1;
        cmd.rd_en     = in_chan.valid;
      end
      ST_EXEC: begin
        // commit only once the output register can take the result
        fire       = !out_valid_r || out_chan.ready;
        cmd.wr_en  = fire && eff.write_row;
        cmd.clr_en = fire && eff.clear_row;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_chan.data;
    end
  end

  // vertex count register, saturating at the matrix size
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= (ResetCount > MaxVertices) ? CountBits'(MaxVertices) : CountBits'(ResetCount);
    end else if (cfg_chan.valid) begin
      count_r <= (int'(cfg_chan.data) > MaxVertices) ? CountBits'(MaxVertices) : cfg_chan.data;
    end
  end

  // present flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (fire && eff.set_present) begin
      present_r[x_idx] <= 1'b1;
    end else if (fire && eff.clear_present) begin
      present_r[x_idx] <= 1'b0;
    end
  end

  amgs_row_mem #(
    .MaxVertices (MaxVertices),
    .WeightBits  (WeightBits)
  ) u_row_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .addr   (mem_addr),
    .wr_row (new_row),
    .rd_row (rd_row)
  );

  amgs_row_eval #(
    .MaxVertices (MaxVertices),
    .WeightBits  (WeightBits)
  ) u_row_eval (
    .req          (req_r),
    .vertex_count (count_r),
    .present_x    (present_r[x_idx]),
    .row          (rd_row),
    .new_row      (new_row),
    .rsp          (rsp),
    .eff          (eff)
  );

  // output register
  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= rsp;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

`default_nettype wire
